// ----- src/xcfp_pkg.sv -----
// Shared constants, state codes, parser state types and character class helpers
// for the XOR-checksum frame parser. No dependencies.
`default_nettype none

package xcfp_pkg;

    localparam logic [7:0] START_CHAR = 8'h24;
    localparam logic [7:0] STAR_CHAR  = 8'h2A;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] MINUS_CHAR = 8'h2D;
    localparam logic [7:0] ZERO_CHAR  = 8'h30;
    localparam logic [7:0] LOWER_X    = 8'h78;
    localparam logic [7:0] UPPER_X    = 8'h58;

    localparam int VALUE_W = 16;
    localparam int CSUM_W  = 8;

    // Frame phase codes.
    localparam logic [1:0] FP_START = 2'd0;
    localparam logic [1:0] FP_DATA  = 2'd1;
    localparam logic [1:0] FP_CHECK = 2'd2;

    // Decimal parser phase codes.
    localparam logic [1:0] DP_SKIP   = 2'd0;
    localparam logic [1:0] DP_DIGITS = 2'd1;
    localparam logic [1:0] DP_DONE   = 2'd2;

    // Hex parser phase codes.
    localparam logic [2:0] HP_SKIP   = 3'd0;
    localparam logic [2:0] HP_SIGN   = 3'd1;
    localparam logic [2:0] HP_ZERO   = 3'd2;
    localparam logic [2:0] HP_PREFIX = 3'd3;
    localparam logic [2:0] HP_DIGITS = 3'd4;
    localparam logic [2:0] HP_DONE   = 3'd5;

    typedef struct packed {
        logic [1:0]         phase;
        logic               negative;
        logic [VALUE_W-1:0] accum;
    } dec_state_t;

    typedef struct packed {
        logic [2:0]        phase;
        logic              negative;
        logic [CSUM_W-1:0] accum;
    } hex_state_t;

    localparam dec_state_t DEC_RESET = '{phase: DP_SKIP, negative: 1'b0, accum: '0};
    localparam hex_state_t HEX_RESET = '{phase: HP_SKIP, negative: 1'b0, accum: '0};

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'h20, [8'h09:8'h0D]};
    endfunction

    function automatic logic is_dec_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_hex_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    // Nibble value of a hex digit; meaningless for other characters.
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        begin
            if (c inside {[8'h30:8'h39]}) begin
                d = c - 8'h30;
            end else if (c inside {[8'h41:8'h46]}) begin
                d = c - 8'h37;
            end else begin
                d = c - 8'h57;
            end
            return d[3:0];
        end
    endfunction

endpackage

`default_nettype wire

// ----- src/xcfp_dec_parse.sv -----
// Next-state logic of the decimal field parser: whitespace skip, sign, digits.
// Depends on xcfp_pkg.
`default_nettype none

module xcfp_dec_parse
    import xcfp_pkg::*;
(
    input  wire logic       feed,
    input  wire logic [7:0] data,
    input  wire dec_state_t cur,
    output dec_state_t      nxt
);

    logic [VALUE_W-1:0] times_ten;
    logic               in_digits;

    assign times_ten = (cur.accum << 3) + (cur.accum << 1);

    always_comb
    begin
        nxt       = cur;
        in_digits = 1'b0;
        if (feed) begin
            case (cur.phase)
                DP_SKIP:
                begin
                    if (data == PLUS_CHAR || data == MINUS_CHAR) begin
                        nxt.negative = (data == MINUS_CHAR);
                        nxt.phase    = DP_DIGITS;
                    end else if (!is_space(data)) begin
                        in_digits = 1'b1;
                    end
                end
                DP_DIGITS: in_digits = 1'b1;
                default:   nxt.phase = cur.phase;
            endcase
            // The first non-space, non-sign character is handled as a digit position.
            if (in_digits) begin
                if (is_dec_digit(data)) begin
                    nxt.accum = times_ten + {{(VALUE_W-4){1'b0}}, data[3:0]};
                    nxt.phase = DP_DIGITS;
                end else begin
                    nxt.phase = DP_DONE;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/xcfp_hex_parse.sv -----
// Next-state logic of the hex checksum parser: whitespace, sign, 0x prefix,
// digits, keeping the low eight bits. Depends on xcfp_pkg.
`default_nettype none

module xcfp_hex_parse
    import xcfp_pkg::*;
(
    input  wire logic       feed,
    input  wire logic [7:0] data,
    input  wire hex_state_t cur,
    output hex_state_t      nxt
);

    logic       digit;
    logic [3:0] nib;

    assign digit = is_hex_digit(data);
    assign nib   = hex_nibble(data);

    always_comb
    begin
        nxt = cur;
        if (feed) begin
            case (cur.phase)
                HP_SKIP, HP_SIGN:
                begin
                    if (cur.phase == HP_SKIP && is_space(data)) begin
                        nxt.phase = HP_SKIP;
                    end else if (cur.phase == HP_SKIP
                                 && (data == PLUS_CHAR || data == MINUS_CHAR)) begin
                        nxt.negative = (data == MINUS_CHAR);
                        nxt.phase    = HP_SIGN;
                    end else if (data == ZERO_CHAR) begin
                        nxt.phase = HP_ZERO;
                    end else if (digit) begin
                        nxt.accum = {4'h0, nib};
                        nxt.phase = HP_DIGITS;
                    end else begin
                        nxt.phase = HP_DONE;
                    end
                end
                HP_ZERO, HP_PREFIX:
                begin
                    if (cur.phase == HP_ZERO && (data == LOWER_X || data == UPPER_X)) begin
                        nxt.phase = HP_PREFIX;
                    end else if (digit) begin
                        nxt.accum = {4'h0, nib};
                        nxt.phase = HP_DIGITS;
                    end else begin
                        nxt.phase = HP_DONE;
                    end
                end
                HP_DIGITS:
                begin
                    if (digit) begin
                        nxt.accum = {cur.accum[3:0], nib};
                    end else begin
                        nxt.phase = HP_DONE;
                    end
                end
                default: nxt.phase = HP_DONE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- src/xor_checksum_frame_parser.sv -----
// Top level of the XOR-checksum frame parser: input register, frame state,
// result register. Depends on xcfp_pkg, xcfp_dec_parse and xcfp_hex_parse.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------
//   in      | input     | in_valid/in_ready  | data_byte, last_byte
//   out     | output    | out_valid/out_ready| frame_ok, value
//
// One byte beat is taken every cycle while no registered last byte waits on a
// result; the rate is set by the update of the frame state from the input register.
// A result is registered in the result register when its last byte leaves the input register.
// Reset returns the parser to the start of a frame and empties both registers.
// A waiting result stalls only a registered last byte; other bytes keep flowing.
`default_nettype none

module xor_checksum_frame_parser
    import xcfp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output wire logic               in_ready,
    input  wire logic [7:0]         data_byte,
    input  wire logic               last_byte,
    output wire logic               out_valid,
    input  wire logic               out_ready,
    output wire logic               frame_ok,
    output wire logic [VALUE_W-1:0] value
);

    logic               in_valid_reg;
    logic [7:0]         byte_reg;
    logic               last_reg;

    logic [1:0]         frame_phase_reg, frame_phase_next;
    logic               start_bad_reg, start_bad_next;
    logic [CSUM_W-1:0]  xor_reg, xor_next;
    dec_state_t         dec_reg, dec_next;
    hex_state_t         hex_reg, hex_next;

    logic               out_valid_reg;
    logic               frame_ok_reg;
    logic [VALUE_W-1:0] value_reg;

    logic               out_free;
    logic               consume;
    logic               in_rdy;
    logic               data_feed;
    logic               hex_feed;
    logic               bad_start;
    logic [CSUM_W-1:0]  recv_csum;
    logic [VALUE_W-1:0] dec_value;
    logic               ok;

    assign out_free = !out_valid_reg || out_ready;
    assign consume  = in_valid_reg && (!last_reg || out_free);
    assign in_rdy   = !in_valid_reg || consume;

    assign bad_start = (frame_phase_reg == FP_START) && (byte_reg != START_CHAR);
    assign data_feed = bad_start || ((frame_phase_reg == FP_DATA) && (byte_reg != STAR_CHAR));
    assign hex_feed  = (frame_phase_reg == FP_CHECK);

    xcfp_dec_parse u_dec (
        .feed (data_feed),
        .data (byte_reg),
        .cur  (dec_reg),
        .nxt  (dec_next)
    );

    xcfp_hex_parse u_hex (
        .feed (hex_feed),
        .data (byte_reg),
        .cur  (hex_reg),
        .nxt  (hex_next)
    );

    always_comb
    begin
        start_bad_next = start_bad_reg | bad_start;
        xor_next       = data_feed ? (xor_reg ^ byte_reg) : xor_reg;
        case (frame_phase_reg)
            FP_START: frame_phase_next = FP_DATA;
            FP_DATA:  frame_phase_next = (byte_reg == STAR_CHAR) ? FP_CHECK : FP_DATA;
            default:  frame_phase_next = FP_CHECK;
        endcase
    end

    // The verdict uses the state after the last byte has been folded in.
    assign recv_csum = hex_next.negative ? (CSUM_W'(0) - hex_next.accum) : hex_next.accum;
    assign dec_value = dec_next.negative ? (VALUE_W'(0) - dec_next.accum) : dec_next.accum;
    assign ok        = !start_bad_next && (frame_phase_next == FP_CHECK)
                       && (recv_csum == xor_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (in_rdy) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_rdy && in_valid) begin
            byte_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            frame_phase_reg <= FP_START;
            start_bad_reg   <= 1'b0;
            xor_reg         <= '0;
            dec_reg         <= DEC_RESET;
            hex_reg         <= HEX_RESET;
        end else if (consume) begin
            if (last_reg) begin
                frame_phase_reg <= FP_START;
                start_bad_reg   <= 1'b0;
                xor_reg         <= '0;
                dec_reg         <= DEC_RESET;
                hex_reg         <= HEX_RESET;
            end else begin
                frame_phase_reg <= frame_phase_next;
                start_bad_reg   <= start_bad_next;
                xor_reg         <= xor_next;
                dec_reg         <= dec_next;
                hex_reg         <= hex_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (consume && last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume && last_reg) begin
            frame_ok_reg <= ok;
            value_reg    <= ok ? dec_value : '0;
        end
    end

    assign in_ready  = in_rdy;
    assign out_valid = out_valid_reg;
    assign frame_ok  = frame_ok_reg;
    assign value     = value_reg;

    // A finished frame always leaves a result behind.
    a_last_makes_result: assert property (@(posedge clk) disable iff (!rst_n)
        consume && last_reg |=> out_valid_reg)
        else $error("last byte consumed without a result");

    // After a frame ends the parser starts clean.
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        consume && last_reg |=> frame_phase_reg == FP_START && xor_reg == '0
                                && !start_bad_reg)
        else $error("frame state not cleared after last byte");

    // A failed frame never reports a value.
    a_fail_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !frame_ok_reg |-> value_reg == '0)
        else $error("value nonzero on failed frame");

    // The input side stalls only behind a waiting result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_rdy |-> in_valid_reg && last_reg && out_valid_reg && !out_ready)
        else $error("input stalled without a pending result");

endmodule

`default_nettype wire
